[src/sqeq_pkg.sv]
// Shared types and constants for the SCI query event queue.
// Holds the request codes, the host command bytes and the sequencer state type.
// No dependencies.
package sqeq_pkg;

    typedef enum logic [1:0] {
        REQ_RAISE = 2'd0,
        REQ_HOST_CMD = 2'd1,
        REQ_PEND_TICK = 2'd2,
        REQ_QUEUE_RESET = 2'd3
    } req_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    localparam logic [7:0] CMD_BURST_A = 8'h80;
    localparam logic [7:0] CMD_BURST_B = 8'h81;
    localparam logic [7:0] CMD_BURST_SET = 8'h82;
    localparam logic [7:0] CMD_BURST_CLR = 8'h83;
    localparam logic [7:0] CMD_QUERY = 8'h84;
    localparam logic [7:0] CMD_ACPI_ON = 8'h86;
    localparam logic [7:0] CMD_ACPI_OFF = 8'h87;

endpackage

[src/sci_query_event_queue_core.sv]
// SCI query event queue: main and pending rings held in synchronous memories.
// Depends on sqeq_pkg for request codes, command bytes and the state type.
// The rings are read at the accepting edge; the execute state then registers the result.
// No beat is accepted in the execute state (write-back) or while m_valid waits on m_ready.
// Reset (aresetn low, synchronous) clears indices, flags and the output valid and sets
// pending_enable; the ring contents are not cleared and need no clearing pass.
module sci_query_event_queue_core
    import sqeq_pkg::*;
#(
    parameter int MAIN_DEPTH = 8,
    parameter int PEND_DEPTH = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_event_code,
    input  logic       s_queue_mode,
    input  logic [7:0] s_host_cmd,
    input  logic       s_host_busy,
    input  logic       s_burst_active,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_query_valid,
    output logic [7:0] m_query_data,
    output logic       m_sci_pulse,
    output logic       m_sci_event_flag,
    output logic       m_acpi_mode_flag,
    output logic       m_burst_check_flag
);

    localparam int MW = $clog2(MAIN_DEPTH);
    localparam int PW = $clog2(PEND_DEPTH);

    function automatic logic [MW-1:0] main_inc(input logic [MW-1:0] idx);
        return (idx == MW'(MAIN_DEPTH - 1)) ? '0 : idx + MW'(1);
    endfunction

    function automatic logic [PW-1:0] pend_inc(input logic [PW-1:0] idx);
        return (idx == PW'(PEND_DEPTH - 1)) ? '0 : idx + PW'(1);
    endfunction

    logic [7:0] main_mem [MAIN_DEPTH];
    logic [7:0] pend_mem [PEND_DEPTH];

    state_t state_reg, state_next;
    logic accept;
    logic exec_en;

    req_t       req_reg;
    logic [7:0] code_reg;
    logic       mode_reg;
    logic [7:0] cmd_reg;
    logic       busy_reg;
    logic       burst_reg;
    logic [7:0] main_rd_reg;
    logic [7:0] pend_rd_reg;

    logic [MW-1:0] main_head_reg, main_head_next;
    logic [MW-1:0] main_tail_reg, main_tail_next;
    logic [PW-1:0] pend_head_reg, pend_head_next;
    logic [PW-1:0] pend_tail_reg, pend_tail_next;
    logic acpi_on_reg, acpi_on_next;
    logic evt_reg, evt_next;
    logic burst_chk_reg, burst_chk_next;
    logic pend_en_reg;

    logic       main_we, pend_we;
    logic [7:0] main_wdata;
    logic       q_valid_c, pulse_c;
    logic [7:0] q_data_c;
    logic [MW-1:0] main_n, main_t;
    logic [PW-1:0] pend_n;

    logic       m_valid_reg;
    logic       q_valid_reg;
    logic [7:0] q_data_reg;
    logic       pulse_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
        exec_en = (state_reg == ST_EXEC);
    end

    assign accept = s_valid && s_ready;

    always_comb begin
        main_head_next = main_head_reg;
        main_tail_next = main_tail_reg;
        pend_head_next = pend_head_reg;
        pend_tail_next = pend_tail_reg;
        acpi_on_next = acpi_on_reg;
        evt_next = evt_reg;
        burst_chk_next = burst_chk_reg;
        main_we = 1'b0;
        pend_we = 1'b0;
        main_wdata = code_reg;
        q_valid_c = 1'b0;
        q_data_c = 8'd0;
        pulse_c = 1'b0;
        main_n = main_inc(main_head_reg);
        main_t = main_inc(main_tail_reg);
        pend_n = pend_inc(pend_head_reg);
        case (req_reg)
            REQ_RAISE: begin
                if (acpi_on_reg) begin
                    if (pend_en_reg && !mode_reg &&
                        ((pend_head_reg != pend_tail_reg) || busy_reg)) begin
                        pend_we = 1'b1;
                        if (pend_n != pend_tail_reg) begin
                            pend_head_next = pend_n;
                        end
                    end else begin
                        main_we = 1'b1;
                        if (main_n != main_tail_reg) begin
                            main_head_next = main_n;
                        end
                        evt_next = 1'b1;
                        pulse_c = 1'b1;
                    end
                end
            end
            REQ_HOST_CMD: begin
                case (cmd_reg)
                    CMD_BURST_A, CMD_BURST_B: begin
                        if (acpi_on_reg && !burst_reg) begin
                            burst_chk_next = 1'b1;
                        end
                    end
                    CMD_BURST_SET: burst_chk_next = 1'b1;
                    CMD_BURST_CLR: burst_chk_next = 1'b0;
                    CMD_QUERY: begin
                        if (main_tail_reg != main_head_reg) begin
                            q_valid_c = 1'b1;
                            q_data_c = main_rd_reg;
                            main_tail_next = main_t;
                            if (main_t == main_head_reg) begin
                                evt_next = 1'b0;
                            end
                        end else begin
                            evt_next = 1'b0;
                        end
                    end
                    CMD_ACPI_ON: acpi_on_next = 1'b1;
                    CMD_ACPI_OFF: acpi_on_next = 1'b0;
                    default: ;
                endcase
            end
            REQ_PEND_TICK: begin
                if (pend_en_reg && acpi_on_reg && (pend_tail_reg != pend_head_reg) &&
                    !busy_reg) begin
                    pend_tail_next = pend_inc(pend_tail_reg);
                    main_we = 1'b1;
                    main_wdata = pend_rd_reg;
                    if (main_n != main_tail_reg) begin
                        main_head_next = main_n;
                    end
                    evt_next = 1'b1;
                    pulse_c = 1'b1;
                end
            end
            REQ_QUEUE_RESET: begin
                main_head_next = '0;
                main_tail_next = '0;
                pend_head_next = '0;
                pend_tail_next = '0;
                evt_next = 1'b0;
                burst_chk_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            main_rd_reg <= main_mem[main_tail_reg];
            pend_rd_reg <= pend_mem[pend_tail_reg];
        end
        if (exec_en && main_we) begin
            main_mem[main_head_reg] <= main_wdata;
        end
        if (exec_en && pend_we) begin
            pend_mem[pend_head_reg] <= code_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= req_t'(s_req_type);
            code_reg <= s_event_code;
            mode_reg <= s_queue_mode;
            cmd_reg <= s_host_cmd;
            busy_reg <= s_host_busy;
            burst_reg <= s_burst_active;
        end
        if (exec_en) begin
            q_valid_reg <= q_valid_c;
            q_data_reg <= q_data_c;
            pulse_reg <= pulse_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            main_head_reg <= '0;
            main_tail_reg <= '0;
            pend_head_reg <= '0;
            pend_tail_reg <= '0;
            acpi_on_reg <= 1'b0;
            evt_reg <= 1'b0;
            burst_chk_reg <= 1'b0;
            pend_en_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                pend_en_reg <= cfg_wdata;
            end
            if (exec_en) begin
                main_head_reg <= main_head_next;
                main_tail_reg <= main_tail_next;
                pend_head_reg <= pend_head_next;
                pend_tail_reg <= pend_tail_next;
                acpi_on_reg <= acpi_on_next;
                evt_reg <= evt_next;
                burst_chk_reg <= burst_chk_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_query_valid = q_valid_reg;
    assign m_query_data = q_data_reg;
    assign m_sci_pulse = pulse_reg;
    assign m_sci_event_flag = evt_reg;
    assign m_acpi_mode_flag = acpi_on_reg;
    assign m_burst_check_flag = burst_chk_reg;

    a_exec_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> !m_valid_reg)
        else $error("Result register still occupied during the execute cycle.");

    a_pop_push_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(q_valid_reg && pulse_reg))
        else $error("A beat both popped and pushed the main ring.");

    a_pulse_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && pulse_reg) |-> evt_reg)
        else $error("SCI pulsed without the event flag set.");

    a_empty_query_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !q_valid_reg) |-> (q_data_reg == 8'd0))
        else $error("Query data non-zero without a returned byte.");

    a_exec_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EXEC))
        else $error("Accepted beat was not executed in the next cycle.");

endmodule
